>>> design/febc_pkg.sv
package febc_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int POS_BITS  = 16;
    localparam int SP_W      = $clog2(MAX_DEPTH);
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 2);
    localparam int CNT_W     = 16;
    localparam int ST_W      = 3;
    localparam int MD_W      = 6;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_CLOSE    = 3'd1;
    localparam logic [ST_W-1:0] ST_QUOTE    = 3'd2;
    localparam logic [ST_W-1:0] ST_OPEN     = 3'd3;
    localparam logic [ST_W-1:0] ST_CAPACITY = 3'd4;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NONE   = 8'h00;

    localparam logic [1:0] QK_NONE   = 2'd0;
    localparam logic [1:0] QK_SINGLE = 2'd1;
    localparam logic [1:0] QK_DOUBLE = 2'd2;

endpackage

>>> design/febc_ram.sv
module febc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/filter_expression_bracket_checker.sv
// Bracket and quote checker for filter expressions.
// Input channel (s_valid/s_ready): one character per transaction in s_ch,
// with s_last marking the final character of an expression. Whitespace
// and quoted spans are skipped, parenthesis depth is tracked from 1, and
// predicate runs are counted.
// Result channel (m_valid/m_ready): one transaction per expression,
// carrying status, err_pos, max_depth and pred_count.
// Throughput: one character per cycle while s_ready is high. Open-paren
// positions sit in a 32-entry stack RAM; a push and the end-of-expression
// lookup of the innermost open each take one RAM port access in the same
// cycle. The result passes through the stage that holds the registered
// stack read, then the output register that drives m_valid.
// Reset: all counters and flags clear, no result is pending; the stack
// RAM is not cleared and needs no clearing pass. After each result the
// state returns to its reset values for the next expression.
// Stall: while m_ready is low the result holds; one more finished result
// can wait behind it, and input stalls only when both are occupied.
module filter_expression_bracket_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_ch,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [febc_pkg::ST_W-1:0]     m_status,
    output logic [febc_pkg::POS_BITS-1:0] m_err_pos,
    output logic [febc_pkg::MD_W-1:0]     m_max_depth,
    output logic [febc_pkg::CNT_W-1:0]    m_pred_count
);
    import febc_pkg::*;

    // scan state
    logic [POS_BITS:0]    pos_reg, pos_next;
    logic [1:0]           quote_reg, quote_next;
    logic                 in_pred_reg, in_pred_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [DEPTH_W-1:0]   peak_reg, peak_next;
    logic [CNT_W-1:0]     preds_reg, preds_next;
    logic [7:0]           pend_reg, pend_next;
    logic                 close_err_reg, close_err_next;
    logic [POS_BITS-1:0]  err_pos_reg, err_pos_next;
    logic [POS_BITS-1:0]  qpos_reg, qpos_next;
    logic                 ovf_reg, ovf_next;

    // result stage waiting on the stack read
    logic                 s2_valid_reg, s2_valid_next;
    logic [ST_W-1:0]      s2_status_reg;
    logic [POS_BITS-1:0]  s2_err_reg;
    logic [MD_W-1:0]      s2_md_reg;
    logic [CNT_W-1:0]     s2_pc_reg;
    logic                 s2_use_stack_reg;
    logic                 s2_fwd_reg;
    logic [POS_BITS-1:0]  s2_fwd_data_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [ST_W-1:0]      m_status_reg;
    logic [POS_BITS-1:0]  m_err_reg;
    logic [MD_W-1:0]      m_md_reg;
    logic [CNT_W-1:0]     m_pc_reg;

    logic                 s_fire;
    logic                 s2_adv;
    logic                 push;
    logic [SP_W-1:0]      wr_addr;
    logic [SP_W-1:0]      rd_addr;
    logic [POS_BITS-1:0]  rd_data;
    logic [ST_W-1:0]      res_status;
    logic [POS_BITS-1:0]  res_err;
    logic [MD_W-1:0]      res_md;
    logic [CNT_W-1:0]     res_pc;
    logic                 res_use_stack;

    assign s2_adv  = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s2_valid_reg || s2_adv;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        logic [DEPTH_W-1:0] wr_idx;
        logic [DEPTH_W-1:0] rd_idx;
        logic [POS_BITS-1:0] idx;

        pos_next       = pos_reg;
        quote_next     = quote_reg;
        in_pred_next   = in_pred_reg;
        depth_next     = depth_reg;
        peak_next      = peak_reg;
        preds_next     = preds_reg;
        pend_next      = pend_reg;
        close_err_next = close_err_reg;
        err_pos_next   = err_pos_reg;
        qpos_next      = qpos_reg;
        ovf_next       = ovf_reg;
        push           = 1'b0;
        res_status     = ST_OK;
        res_err        = '0;
        res_md         = MD_W'(1);
        res_pc         = '0;
        res_use_stack  = 1'b0;
        idx            = pos_reg[POS_BITS-1:0];
        wr_idx         = depth_reg - DEPTH_W'(1);
        wr_addr        = wr_idx[SP_W-1:0];

        if (!close_err_reg && !ovf_reg) begin
            if (pos_reg[POS_BITS]) begin
                ovf_next = 1'b1;
            end else begin
                // a pending | or & looks at the raw next character
                if (pend_reg != CH_NONE) begin
                    if (s_ch == pend_reg) begin
                        in_pred_next = 1'b0;
                    end else if (!in_pred_next) begin
                        if (preds_next != '1) preds_next = preds_next + CNT_W'(1);
                        in_pred_next = 1'b1;
                    end
                    pend_next = CH_NONE;
                end
                if (s_ch == CH_SPACE || (s_ch >= CH_TAB && s_ch <= CH_CR)) begin
                    // whitespace
                end else if (quote_reg != QK_NONE) begin
                    if ((quote_reg == QK_SINGLE && s_ch == CH_SQUOTE) ||
                        (quote_reg == QK_DOUBLE && s_ch == CH_DQUOTE)) begin
                        quote_next = QK_NONE;
                    end
                end else begin
                    case (s_ch) inside
                        CH_SQUOTE, CH_DQUOTE: begin
                            quote_next = (s_ch == CH_SQUOTE) ? QK_SINGLE : QK_DOUBLE;
                            qpos_next  = idx;
                            if (!in_pred_next) begin
                                if (preds_next != '1) preds_next = preds_next + CNT_W'(1);
                                in_pred_next = 1'b1;
                            end
                        end
                        CH_BAR, CH_AMP: begin
                            pend_next = s_ch;
                        end
                        CH_OPEN: begin
                            in_pred_next = 1'b0;
                            if (depth_reg > DEPTH_W'(MAX_DEPTH)) begin
                                ovf_next = 1'b1;
                            end else begin
                                push       = 1'b1;
                                depth_next = depth_reg + DEPTH_W'(1);
                                if (depth_next > peak_reg) peak_next = depth_next;
                            end
                        end
                        CH_CLOSE: begin
                            in_pred_next = 1'b0;
                            if (depth_reg <= DEPTH_W'(1)) begin
                                close_err_next = 1'b1;
                                err_pos_next   = idx;
                            end else begin
                                depth_next = depth_reg - DEPTH_W'(1);
                            end
                        end
                        default: begin
                            if (!in_pred_next) begin
                                if (preds_next != '1) preds_next = preds_next + CNT_W'(1);
                                in_pred_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
        if (!pos_reg[POS_BITS]) pos_next = pos_reg + (POS_BITS+1)'(1);

        // innermost open after this character
        rd_idx  = depth_next - DEPTH_W'(2);
        rd_addr = rd_idx[SP_W-1:0];

        if (s_last) begin
            // trailing operator counts as a predicate character
            if (!close_err_next && !ovf_next && pend_next != CH_NONE) begin
                if (!in_pred_next && preds_next != '1) preds_next = preds_next + CNT_W'(1);
            end
            if (ovf_next) begin
                res_status = ST_CAPACITY;
            end else if (close_err_next) begin
                res_status = ST_CLOSE;
                res_err    = err_pos_next;
            end else if (quote_next != QK_NONE) begin
                res_status = ST_QUOTE;
                res_err    = qpos_next;
            end else if (depth_next != DEPTH_W'(1)) begin
                res_status    = ST_OPEN;
                res_use_stack = 1'b1;
            end else begin
                res_md = MD_W'(peak_next);
                res_pc = preds_next;
            end
            pos_next       = '0;
            quote_next     = QK_NONE;
            in_pred_next   = 1'b0;
            depth_next     = DEPTH_W'(1);
            peak_next      = DEPTH_W'(1);
            preds_next     = '0;
            pend_next      = CH_NONE;
            close_err_next = 1'b0;
            err_pos_next   = '0;
            qpos_next      = '0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            quote_reg     <= QK_NONE;
            in_pred_reg   <= 1'b0;
            depth_reg     <= DEPTH_W'(1);
            peak_reg      <= DEPTH_W'(1);
            preds_reg     <= '0;
            pend_reg      <= CH_NONE;
            close_err_reg <= 1'b0;
            err_pos_reg   <= '0;
            qpos_reg      <= '0;
            ovf_reg       <= 1'b0;
        end else if (s_fire) begin
            pos_reg       <= pos_next;
            quote_reg     <= quote_next;
            in_pred_reg   <= in_pred_next;
            depth_reg     <= depth_next;
            peak_reg      <= peak_next;
            preds_reg     <= preds_next;
            pend_reg      <= pend_next;
            close_err_reg <= close_err_next;
            err_pos_reg   <= err_pos_next;
            qpos_reg      <= qpos_next;
            ovf_reg       <= ovf_next;
        end
    end

    // the read holds its data until the next last transaction
    febc_ram #(
        .WIDTH(POS_BITS),
        .DEPTH(MAX_DEPTH)
    ) u_stack (
        .clk   (aclk),
        .we    (s_fire && push),
        .waddr (wr_addr),
        .wdata (pos_reg[POS_BITS-1:0]),
        .re    (s_fire && s_last),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (s_fire && s_last) begin
            s2_valid_next = 1'b1;
        end else if (s2_adv) begin
            s2_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s2_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_last) begin
            s2_status_reg    <= res_status;
            s2_err_reg       <= res_err;
            s2_md_reg        <= res_md;
            s2_pc_reg        <= res_pc;
            s2_use_stack_reg <= res_use_stack;
            // a push in the last cycle lands on the address being read
            s2_fwd_reg       <= push;
            s2_fwd_data_reg  <= pos_reg[POS_BITS-1:0];
        end
        if (s2_adv) begin
            m_status_reg <= s2_status_reg;
            m_md_reg     <= s2_md_reg;
            m_pc_reg     <= s2_pc_reg;
            if (!s2_use_stack_reg) begin
                m_err_reg <= s2_err_reg;
            end else if (s2_fwd_reg) begin
                m_err_reg <= s2_fwd_data_reg;
            end else begin
                m_err_reg <= rd_data;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_err_pos    = m_err_reg;
    assign m_max_depth  = m_md_reg;
    assign m_pred_count = m_pc_reg;

endmodule

>>> design/febc_checker.sv
module febc_assertions (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [febc_pkg::ST_W-1:0]     m_status,
    input  logic [febc_pkg::POS_BITS-1:0] m_err_pos,
    input  logic [febc_pkg::MD_W-1:0]     m_max_depth,
    input  logic [febc_pkg::CNT_W-1:0]    m_pred_count
);
    import febc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_err_pos)
            && $stable(m_max_depth) && $stable(m_pred_count))
        else $error("result changed while stalled");

    a_fail_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_max_depth == MD_W'(1) && m_pred_count == '0)
        else $error("failed result carries depth or count");

    a_no_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OK || m_status == ST_CAPACITY) |-> m_err_pos == '0)
        else $error("error position on a result without one");

    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_max_depth >= MD_W'(1) && m_max_depth <= MD_W'(MAX_DEPTH + 1))
        else $error("peak depth out of range");

    // input can only stall when a result is waiting
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with output free");

endmodule

bind filter_expression_bracket_checker febc_assertions u_febc_assertions (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_err_pos    (m_err_pos),
    .m_max_depth  (m_max_depth),
    .m_pred_count (m_pred_count)
);
